>>> rtl/pew_pkg.sv
// ----------------------------------------------------------------------------
// pew_pkg
// Shared constants for the Prewitt edge magnitude core: field widths,
// configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package pew_pkg;

  localparam int MAG_W        = 11;
  localparam int ROW_W        = 12;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int MIN_DIM      = 3;
  localparam int MAG_MAX      = 2047;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

endpackage

>>> rtl/prewitt_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_core
// Pipeline: an accepted pixel passes through line store read, gradient,
//   squares, radicand, the chain of PIXEL_BITS+3 square root cells (one
//   root bit per cell) and the output register, each stage registered.
// Throughput: one pixel per cycle while results are taken; every stage is
//   registered with its own valid, so a waiting result stalls the chain once it is full.
// Reset: clears counters, window and valids; registers return to 640 x 480;
//   line stores are not cleared.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_core
  import pew_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: pixel_value
  input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: frame_start
  input  logic [0:0]            s_tuser,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: edge_magnitude, center_row, center_col
  output logic [((MAG_W+ROW_W+$clog2(MAX_WIDTH)+7)/8)*8-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH+1);
  localparam int P      = PIXEL_BITS;
  localparam int N      = PIXEL_BITS + 3;
  localparam int SIDE_W = ROW_W + CW + 1;
  localparam int OUT_W  = ((MAG_W+ROW_W+CW+7)/8)*8;

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [ROW_W-1:0]        row_count;
  logic [CW-1:0]           col_count;

  logic [WW-1:0]     w_eff, w_m1;
  logic [ROW_W-1:0]  h_eff, h_m1;
  logic [ROW_W-1:0]  eff_row;
  logic [CW-1:0]     eff_col;
  logic              emit;
  logic              last;
  logic [SIDE_W-1:0] in_side;
  logic              accept;

  logic                g_v, g_ready;
  logic signed [P+2:0] g_gx, g_gy;
  logic [SIDE_W-1:0]   g_side;

  logic [P+2:0]       gx_abs, gy_abs;
  logic [2*P+3:0]     sqx_next, sqy_next;
  logic               q_v, q_ready;
  logic [2*P+3:0]     q_sqx, q_sqy;
  logic [SIDE_W-1:0]  q_side;
  logic               r_ready;

  logic              h_v;
  logic [2*N-1:0]    h_rad;
  logic [SIDE_W-1:0] h_side;

  logic              cv   [N+1];
  logic              crdy [N+1];
  logic [N+1:0]      crem [N+1];
  logic [N-1:0]      croot[N+1];
  logic [2*N-1:0]    crad [N+1];
  logic [SIDE_W-1:0] cside[N+1];

  logic [MAG_W-1:0]  mag_next;
  logic [MAG_W-1:0]  o_mag;
  logic [SIDE_W-1:0] o_side;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(image_width) < MIN_DIM) begin
      w_eff = WW'(MIN_DIM);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff = (int'(image_height) < MIN_DIM) ? ROW_W'(MIN_DIM) : image_height;
    w_m1  = w_eff - 1'b1;
    h_m1  = h_eff - 1'b1;
  end

  // position tracking
  assign accept  = s_tvalid && s_tready;
  assign eff_row = s_tuser[0] ? '0 : row_count;
  assign eff_col = s_tuser[0] ? '0 : col_count;

  always_comb begin
    emit = (eff_row >= ROW_W'(2)) && (eff_col >= CW'(2)) &&
           (eff_row < h_eff) && (WW'(eff_col) < w_eff);
    last = (eff_row == h_m1) && (WW'(eff_col) == w_m1);
    in_side = {last, eff_col - 1'b1, eff_row - 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (WW'(eff_col) >= w_m1) begin
        col_count <= '0;
        row_count <= (eff_row >= h_m1) ? '0 : eff_row + 1'b1;
      end else begin
        col_count <= eff_col + 1'b1;
        row_count <= eff_row;
      end
    end
  end

  pew_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .SIDE_W     (SIDE_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pix    (s_tdata[P-1:0]),
    .in_col    (eff_col),
    .in_emit   (emit),
    .in_side   (in_side),
    .out_valid (g_v),
    .out_ready (g_ready),
    .out_gx    (g_gx),
    .out_gy    (g_gy),
    .out_side  (g_side)
  );

  // squares
  assign g_ready = q_ready;
  assign q_ready = !q_v || r_ready;

  always_comb begin
    gx_abs   = g_gx[P+2] ? (P+3)'(-g_gx) : (P+3)'(g_gx);
    gy_abs   = g_gy[P+2] ? (P+3)'(-g_gy) : (P+3)'(g_gy);
    sqx_next = (2*P+4)'(gx_abs[P+1:0]) * (2*P+4)'(gx_abs[P+1:0]);
    sqy_next = (2*P+4)'(gy_abs[P+1:0]) * (2*P+4)'(gy_abs[P+1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (q_ready) begin
      q_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (g_v && q_ready) begin
      q_sqx  <= sqx_next;
      q_sqy  <= sqy_next;
      q_side <= g_side;
    end
  end

  // radicand, head of the root chain
  assign r_ready = !h_v || crdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (r_ready) begin
      h_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (q_v && r_ready) begin
      h_rad  <= (2*N)'(q_sqx) + (2*N)'(q_sqy);
      h_side <= q_side;
    end
  end

  assign cv[0]    = h_v;
  assign crad[0]  = h_rad;
  assign cside[0] = h_side;
  assign crem[0]  = '0;
  assign croot[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    pew_sqrt_cell #(.N(N), .SIDE_W(SIDE_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (crdy[k]),
      .in_rem    (crem[k]),
      .in_root   (croot[k]),
      .in_rad    (crad[k]),
      .in_side   (cside[k]),
      .out_valid (cv[k+1]),
      .out_ready (crdy[k+1]),
      .out_rem   (crem[k+1]),
      .out_root  (croot[k+1]),
      .out_rad   (crad[k+1]),
      .out_side  (cside[k+1])
    );
  end

  // output register
  assign crdy[N] = !m_tvalid || m_tready;

  always_comb begin
    if (int'(croot[N]) > MAG_MAX) begin
      mag_next = '1;
    end else begin
      mag_next = MAG_W'(croot[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (crdy[N]) begin
      m_tvalid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (cv[N] && crdy[N]) begin
      o_mag  <= mag_next;
      o_side <= cside[N];
    end
  end

  assign m_tdata = OUT_W'({o_side[SIDE_W-2:0], o_mag});
  assign m_tlast = o_side[SIDE_W-1];

  a_frame_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser[0] |=> (col_count == CW'(1)) && (row_count == '0))
    else $error("frame start did not restart the position counters");

  a_last_is_corner: assert property (@(posedge clk) disable iff (rst)
    accept && emit && last |-> (WW'(eff_col) == w_m1) && (eff_row == h_m1))
    else $error("frame end flag set away from the last interior pixel");

endmodule

>>> rtl/pew_ram.sv
// ----------------------------------------------------------------------------
// pew_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module pew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> rtl/pew_window.sv
// ----------------------------------------------------------------------------
// pew_window
// Two line stores and the 3x3 window. Reads the stores for each pixel,
// shifts the window and produces the horizontal and vertical gradients.
// ----------------------------------------------------------------------------
module pew_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int SIDE_W     = 23
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PIXEL_BITS-1:0]        in_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
  input  logic                         in_emit,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PIXEL_BITS+2:0] out_gx,
  output logic signed [PIXEL_BITS+2:0] out_gy,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int P  = PIXEL_BITS;

  logic            s0_v;
  logic [P-1:0]    s0_pix;
  logic [CW-1:0]   s0_col;
  logic            s0_emit;
  logic [SIDE_W-1:0] s0_side;
  logic [P-1:0]    win [6];
  logic [P-1:0]    up_rdata;
  logic [P-1:0]    md_rdata;
  logic            accept;
  logic            s0_fire;
  logic            g_ready;
  logic [P+1:0]    sum_bot, sum_top, sum_right, sum_left;
  logic signed [P+2:0] gx_next, gy_next;

  assign g_ready  = !out_valid || out_ready;
  assign in_ready = !s0_v || g_ready;
  assign accept   = in_valid && in_ready;
  assign s0_fire  = s0_v && g_ready;

  pew_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk     (clk),
    .wr_en   (s0_fire),
    .wr_addr (s0_col),
    .wr_data (md_rdata),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (up_rdata)
  );

  pew_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk     (clk),
    .wr_en   (s0_fire),
    .wr_addr (s0_col),
    .wr_data (s0_pix),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (md_rdata)
  );

  // win[0..2]: column c-1 top/mid/bottom, win[3..5]: column c-2
  always_comb begin
    sum_bot   = (P+2)'(win[2]) + (P+2)'(win[5]) + (P+2)'(s0_pix);
    sum_top   = (P+2)'(win[0]) + (P+2)'(win[3]) + (P+2)'(up_rdata);
    sum_right = (P+2)'(up_rdata) + (P+2)'(md_rdata) + (P+2)'(s0_pix);
    sum_left  = (P+2)'(win[3]) + (P+2)'(win[4]) + (P+2)'(win[5]);
    gx_next   = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
    gy_next   = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s0_v <= in_valid;
      end
      if (g_ready) begin
        out_valid <= s0_v && s0_emit;
      end
      if (s0_fire) begin
        win[3] <= win[0];
        win[4] <= win[1];
        win[5] <= win[2];
        win[0] <= up_rdata;
        win[1] <= md_rdata;
        win[2] <= s0_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pix  <= in_pix;
      s0_col  <= in_col;
      s0_emit <= in_emit;
      s0_side <= in_side;
    end
    if (s0_fire) begin
      out_gx   <= gx_next;
      out_gy   <= gy_next;
      out_side <= s0_side;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> s0_v)
    else $error("accepted pixel did not reach the window stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_gx) && $stable(out_gy))
    else $error("gradient stage lost data while stalled");

endmodule

>>> rtl/pew_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pew_sqrt_cell
// One step of the restoring integer square root. Resolves one root bit,
// registers remainder, partial root and remaining radicand, and hands them
// to the next cell together with the side data.
// ----------------------------------------------------------------------------
module pew_sqrt_cell #(
  parameter int N      = 11,
  parameter int SIDE_W = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N+1:0]      in_rem,
  input  logic [N-1:0]      in_root,
  input  logic [2*N-1:0]    in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [N+1:0]      out_rem,
  output logic [N-1:0]      out_root,
  output logic [2*N-1:0]    out_rad,
  output logic [SIDE_W-1:0] out_side
);

  logic [N+2:0] trial_a;
  logic [N+2:0] trial_b;
  logic [N+2:0] diff;
  logic         ge;
  logic [N+1:0] rem_next;
  logic [N-1:0] root_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    trial_a   = {1'b0, in_rem[N-1:0], in_rad[2*N-1:2*N-2]};
    trial_b   = {1'b0, in_root, 2'b01};
    diff      = trial_a - trial_b;
    ge        = !diff[N+2];
    rem_next  = ge ? diff[N+1:0] : trial_a[N+1:0];
    root_next = {in_root[N-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rem  <= rem_next;
      out_root <= root_next;
      out_rad  <= {in_rad[2*N-3:0], 2'b00};
      out_side <= in_side;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem <= (N+2)'({out_root, 1'b0}))
    else $error("square root remainder exceeds twice the partial root");

  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_root))
    else $error("square root cell dropped a stalled transaction");

endmodule
